>>> design/bie_pkg.sv
// shared types and constants for the bitmap intersection block
`timescale 1ns / 1ps
package bie_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_IDX_W = 5;
    localparam int SECTION_W = 12;
    localparam int DOC_W     = SECTION_W + BIT_IDX_W;

    // one section whose intersection is nonzero, handed from front to back
    typedef struct packed {
        logic [WORD_BITS-1:0] hits;
        logic [SECTION_W-1:0] section;
    } bie_job_t;

endpackage

>>> design/bie_front.sv
// front end: takes bitmap words, ANDs them per section, queues finished sections
`timescale 1ns / 1ps
module bie_front
    import bie_pkg::*;
#(
    parameter int SECTION_COUNT = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  logic [WORD_BITS-1:0] bitmap_word,
    input  logic [SECTION_W-1:0] section_index,
    input  logic                 last_term,
    output logic                 job_push,
    output bie_job_t             job
);

    localparam int LIMIT_W = 21;
    localparam logic [LIMIT_W-1:0] SECTION_LIMIT = LIMIT_W'(SECTION_COUNT);

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic                 fresh_reg, fresh_next;
    logic                 accept;
    logic                 in_range;
    logic [WORD_BITS-1:0] combined;

    assign accept   = push && !full;
    assign in_range = {{(LIMIT_W-SECTION_W){1'b0}}, section_index} < SECTION_LIMIT;
    assign combined = fresh_reg ? bitmap_word : (acc_reg & bitmap_word);

    always_comb
    begin
        acc_next   = acc_reg;
        fresh_next = fresh_reg;
        job_push   = 1'b0;
        if (accept && in_range)
        begin
            if (last_term)
            begin
                acc_next   = '1;
                fresh_next = 1'b1;
                job_push   = (combined != '0);
            end
            else
            begin
                acc_next   = combined;
                fresh_next = 1'b0;
            end
        end
    end

    assign job.hits    = combined;
    assign job.section = section_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '1;
            fresh_reg <= 1'b1;
        end
        else
        begin
            acc_reg   <= acc_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

>>> design/bie_queue.sv
// short job queue between front and back end
`timescale 1ns / 1ps
module bie_queue
    import bie_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  bie_job_t wr_job,
    input  logic     rd_en,
    output bie_job_t rd_job,
    output logic     q_full,
    output logic     q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bie_job_t         store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == FULL_CNT);
    assign q_empty = (count_reg == '0);
    assign rd_job  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/bie_back.sv
// back end: peels set bits off a queued section, one document per cycle while results are popped
`timescale 1ns / 1ps
module bie_back
    import bie_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  bie_job_t         rd_job,
    output logic             rd_en,
    input  logic             pop,
    output logic             empty,
    output logic [DOC_W-1:0] doc_id,
    output logic             last_of_run
);

    bie_job_t             work_reg, work_next;
    logic                 work_valid_reg, work_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DOC_W-1:0]     doc_reg;
    logic                 last_reg;
    logic                 advance;
    logic [WORD_BITS-1:0] remaining;
    logic [WORD_BITS-1:0] lowest;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic                 work_free;

    // isolate lowest set bit, then encode its position
    assign lowest    = work_reg.hits & (~work_reg.hits + 1'b1);
    assign remaining = work_reg.hits & ~lowest;

    always_comb
    begin
        bit_pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (lowest[i])
                bit_pos = bit_pos | BIT_IDX_W'(i);
        end
    end

    assign advance   = work_valid_reg && (!out_valid_reg || pop);
    assign work_free = !work_valid_reg || (advance && (remaining == '0));
    assign rd_en     = work_free && !q_empty;

    always_comb
    begin
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        out_valid_next  = out_valid_reg;
        if (rd_en)
        begin
            work_next       = rd_job;
            work_valid_next = 1'b1;
        end
        else if (advance)
        begin
            work_next.hits  = remaining;
            work_valid_next = (remaining != '0);
        end
        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (advance)
        begin
            doc_reg  <= {work_reg.section, bit_pos};
            last_reg <= (remaining == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign doc_id      = doc_reg;
    assign last_of_run = last_reg;

endmodule

>>> design/bitmap_intersect_doc_extract.sv
// top level of the posting-list bitmap intersection and document extraction block
`timescale 1ns / 1ps
// Bitmap words of the query terms come in one item per cycle, each tagged with
// its 32-document section and a flag on the final term's word. The front end
// ANDs the words of a section as they arrive (a word whose section is not below
// SECTION_COUNT is dropped) and, on the final term, hands any nonzero result to a
// QUEUE_DEPTH-entry job queue. The back end turns each queued word into document
// numbers section*32+bit, lowest bit first, one per cycle while results are
// popped, and flags the last document of the section with last_of_run. Input is
// taken every cycle while the job queue has room; a section's documents hold the
// back end until all are out, so input stalls only when the queue fills behind
// words with many set bits or a stalled receiver. A result sits in an output
// register until popped. Sections with an empty intersection produce nothing.
module bitmap_intersect_doc_extract
    import bie_pkg::*;
#(
    parameter int SECTION_COUNT = 4096,
    parameter int QUEUE_DEPTH   = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input side
    input  logic                 push,
    output logic                 full,
    input  logic [WORD_BITS-1:0] bitmap_word,
    input  logic [SECTION_W-1:0] section_index,
    input  logic                 last_term,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output logic [DOC_W-1:0]     doc_id,
    output logic                 last_of_run
);

    logic     job_push;
    bie_job_t job_in;
    bie_job_t job_out;
    logic     job_pop;
    logic     q_full;
    logic     q_empty;

    // input is held off only by a full job queue
    assign full = q_full;

    bie_front #(
        .SECTION_COUNT (SECTION_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (q_full),
        .bitmap_word   (bitmap_word),
        .section_index (section_index),
        .last_term     (last_term),
        .job_push      (job_push),
        .job           (job_in)
    );

    bie_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (job_in),
        .rd_en   (job_pop),
        .rd_job  (job_out),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    bie_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .rd_job      (job_out),
        .rd_en       (job_pop),
        .pop         (pop),
        .empty       (empty),
        .doc_id      (doc_id),
        .last_of_run (last_of_run)
    );

    // the front never writes a job into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_full)
        else $error("job written into full queue");

    // the back never reads an empty queue
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !q_empty)
        else $error("job read from empty queue");

    // within a run the next document follows at once, same section, higher bit
    a_run_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=>
            (!empty && (doc_id[DOC_W-1:BIT_IDX_W] == $past(doc_id[DOC_W-1:BIT_IDX_W]))
             && (doc_id[BIT_IDX_W-1:0] > $past(doc_id[BIT_IDX_W-1:0]))))
        else $error("run of documents broken or out of order");

    // a full queue always holds work
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty)
        else $error("queue reports full and empty");

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the posting-list bitmap intersection block
`timescale 1ns / 1ps
module tb_top;
    import bie_pkg::*;

    localparam int SECTION_LIMIT = 4096;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int N_DIRECTED    = 23;
    localparam int RANDOM_ITEMS  = 50;    // per idling phase
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off in the pressure phase

    // one document number as it should leave the block
    typedef struct packed {
        logic [DOC_W-1:0] doc;
        logic             last;
    } doc_hit_t;

    // one directed item; typed rows carry their answer, the rest use the predictor
    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic [SECTION_W-1:0] section;
        logic                 last;
        bit                   typed;
        int                   exp_n;
        logic [DOC_W-1:0]     exp_doc;
    } query_row_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 push          = 1'b0;
    logic                 full;
    logic [WORD_BITS-1:0] bitmap_word   = '0;
    logic [SECTION_W-1:0] section_index = '0;
    logic                 last_term     = 1'b0;
    logic                 empty;
    logic                 pop           = 1'b0;
    logic [DOC_W-1:0]     doc_id;
    logic                 last_of_run;

    // predictor state, mirrors the block after reset
    logic [WORD_BITS-1:0] running_and   = '1;
    logic                 section_fresh = 1'b1;
    doc_hit_t             pending_docs[$];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;

    int send_idle_by_phase[4] = '{0, 88, 0, 21};
    int recv_stall_by_phase[4] = '{0, 0, 88, 21};

    // directed items: extremes of word and section, multi-term runs, empty
    // intersections, mixed sections and single-term runs
    query_row_t directed_rows[N_DIRECTED] = '{
        // single term right after reset, lowest document
        '{32'h0000_0001, 12'd0,    1'b1, 1'b1, 1, 17'd0},
        // highest document number
        '{32'h8000_0000, 12'd4095, 1'b1, 1'b1, 1, 17'd131071},
        // all-zero word on the last term emits nothing
        '{32'h0000_0000, 12'd5,    1'b1, 1'b1, 0, 17'd0},
        // full word at both section extremes
        '{32'hFFFF_FFFF, 12'd4095, 1'b1, 1'b0, 0, 17'd0},
        '{32'hFFFF_FFFF, 12'd0,    1'b1, 1'b0, 0, 17'd0},
        // three terms on one section
        '{32'hF0F0_F0F0, 12'd100,  1'b0, 1'b1, 0, 17'd0},
        '{32'hFF00_FF00, 12'd100,  1'b0, 1'b1, 0, 17'd0},
        '{32'h1FF0_1FF0, 12'd100,  1'b1, 1'b0, 0, 17'd0},
        // disjoint terms
        '{32'hAAAA_AAAA, 12'd7,    1'b0, 1'b1, 0, 17'd0},
        '{32'h5555_5555, 12'd7,    1'b1, 1'b1, 0, 17'd0},
        // mixed sections, ids follow the last-term section
        '{32'hFFFF_0000, 12'd1,    1'b0, 1'b1, 0, 17'd0},
        '{32'h0003_0000, 12'd2000, 1'b1, 1'b0, 0, 17'd0},
        // zero first term keeps the run empty
        '{32'h0000_0000, 12'd3,    1'b0, 1'b1, 0, 17'd0},
        '{32'hFFFF_FFFF, 12'd3,    1'b1, 1'b1, 0, 17'd0},
        // accumulator is back to all ones after an empty run
        '{32'h0000_0004, 12'd10,   1'b1, 1'b1, 1, 17'd322},
        // alternating bit patterns on word and section
        '{32'h5555_5555, 12'hAAA,  1'b1, 1'b0, 0, 17'd0},
        '{32'hAAAA_AAAA, 12'h555,  1'b1, 1'b0, 0, 17'd0},
        // long run ending at both ends of the word
        '{32'hFFFF_FFFF, 12'd4095, 1'b0, 1'b1, 0, 17'd0},
        '{32'hFFFF_FFFF, 12'd4095, 1'b0, 1'b1, 0, 17'd0},
        '{32'h8000_0001, 12'd4095, 1'b1, 1'b0, 0, 17'd0},
        '{32'h0000_0000, 12'd4095, 1'b0, 1'b1, 0, 17'd0},
        '{32'hFFFF_FFFF, 12'd4095, 1'b1, 1'b1, 0, 17'd0},
        '{32'hFFFF_FFFF, 12'd9,    1'b1, 1'b0, 0, 17'd0}
    };

    bitmap_intersect_doc_extract #(
        .SECTION_COUNT (SECTION_LIMIT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .bitmap_word   (bitmap_word),
        .section_index (section_index),
        .last_term     (last_term),
        .empty         (empty),
        .pop           (pop),
        .doc_id        (doc_id),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // AND one accepted word into the running intersection; on the last term
    // queue one document per set bit, lowest first, and flag the highest
    function automatic void intersect_word(input logic [WORD_BITS-1:0] word,
                                           input logic [SECTION_W-1:0] sec,
                                           input logic last, input bit record);
        logic [WORD_BITS-1:0] combined;
        int                   top;
        doc_hit_t             hit;
        if (sec >= SECTION_LIMIT)
            return;
        combined = section_fresh ? word : (running_and & word);
        if (!last)
        begin
            running_and   = combined;
            section_fresh = 1'b0;
            return;
        end
        top = -1;
        for (int b = 0; b < WORD_BITS; b++)
            if (combined[b])
                top = b;
        if (record)
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                if (combined[b])
                begin
                    hit.doc  = {sec, BIT_IDX_W'(b)};
                    hit.last = (b == top);
                    pending_docs.push_back(hit);
                end
            end
        end
        running_and   = '1;
        section_fresh = 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what, input doc_hit_t want);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): expected doc %0d last %0b, got doc %0d last %0b",
                     what, want.doc, want.last, doc_id, last_of_run);
    endfunction

    // offer one item from a falling edge, hold it until taken, then return at
    // the next falling edge; random idle cycles go in front of it
    task automatic send_item(input logic [WORD_BITS-1:0] word,
                             input logic [SECTION_W-1:0] sec,
                             input logic last, input bit record);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push          <= 1'b1;
        bitmap_word   <= word;
        section_index <= sec;
        last_term     <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        intersect_word(word, sec, last, record);
        @(negedge clk);
    endtask

    // mostly well-formed query runs with random content, plus stray words and
    // runs whose sections drift
    task automatic send_query_runs(input int n_items);
        int                   sent;
        int                   kind;
        int                   n_terms;
        logic [WORD_BITS-1:0] core;
        logic [WORD_BITS-1:0] w;
        logic [SECTION_W-1:0] sec;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            if ($urandom_range(9) == 0)
                sec = $urandom_range(1) ? '1 : '0;
            else
                sec = SECTION_W'($urandom);
            if (kind < 80)
            begin
                // terms share a core so the intersection is usually nonzero
                n_terms = $urandom_range(1, 4);
                core = ($urandom_range(3) == 0) ? ($urandom & $urandom) : $urandom;
                for (int t = 0; t < n_terms; t++)
                begin
                    w = core | ($urandom & $urandom & $urandom);
                    send_item(w, sec, t == n_terms - 1, 1'b1);
                    sent++;
                end
            end
            else if (kind < 92)
            begin
                if ($urandom_range(1))
                    w = $urandom;
                else
                    w = $urandom_range(1) ? '1 : '0;
                send_item(w, sec, 1'($urandom_range(1)), 1'b1);
                sent++;
            end
            else
            begin
                n_terms = $urandom_range(2, 3);
                for (int t = 0; t < n_terms; t++)
                begin
                    send_item($urandom | $urandom, SECTION_W'($urandom),
                              t == n_terms - 1, 1'b1);
                    sent++;
                end
            end
        end
    endtask

    // receiver: random stalls, or a counted hold-off that lets the block fill up
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            pop <= 1'b0;
            hold_off_cycles--;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every document taken is compared with the oldest one expected
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_docs.size() == 0)
                flag_mismatch("no item expected", '0);
            else if (doc_id !== pending_docs[0].doc || last_of_run !== pending_docs[0].last)
                flag_mismatch("wrong item", pending_docs.pop_front());
            else
                void'(pending_docs.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still expected",
                     cycle_count, pending_docs.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table, no idling on either side
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_item(directed_rows[r].word, directed_rows[r].section,
                      directed_rows[r].last, !directed_rows[r].typed);
            if (directed_rows[r].typed && directed_rows[r].exp_n == 1)
                pending_docs.push_back('{doc: directed_rows[r].exp_doc, last: 1'b1});
        end

        // random runs under each idling mix
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_idle_by_phase[p];
            recv_stall_pct = recv_stall_by_phase[p];
            send_query_runs(RANDOM_ITEMS);
        end

        // pressure: receiver holds off while the sender keeps pushing
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = HOLD_CYCLES;
        send_query_runs(RANDOM_ITEMS);

        push <= 1'b0;
        recv_stall_pct = 0;
        while (pending_docs.size() != 0)
            @(posedge clk);
        // catch any stray item the block still emits
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> bitmap_intersect_doc_extract.f
design/bie_pkg.sv
design/bie_front.sv
design/bie_queue.sv
design/bie_back.sv
design/bitmap_intersect_doc_extract.sv
bench/tb_top.sv
